/* sv/clr_pkg.sv */
// Shared types and constants for the clipped line rasterizer.
// Used by every module of the block; depends on nothing else.
package clr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ADDR_BITS_DEF  = 24;

    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int COLOR_W     = 32;
    localparam int CLIP_POS_W  = 12;
    localparam int CLIP_SIZE_W = 13;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        REG_CLIP_LEFT   = 3'd0,
        REG_CLIP_TOP    = 3'd1,
        REG_CLIP_WIDTH  = 3'd2,
        REG_CLIP_HEIGHT = 3'd3,
        REG_ROW_STRIDE  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [CLIP_POS_W-1:0]  clip_left;
        logic [CLIP_POS_W-1:0]  clip_top;
        logic [CLIP_SIZE_W-1:0] clip_width;
        logic [CLIP_SIZE_W-1:0] clip_height;
        logic [CLIP_SIZE_W-1:0] row_stride;
    } t_clip_cfg;

    // Status of the pixel held in the walker stage.
    typedef struct packed {
        logic live;   // word came from a start or from a step of an active line
        logic last;   // endpoint reached, or no line active
    } t_pix_ctl;

endpackage

/* sv/clr_regs.sv */
// Configuration registers of the clipped line rasterizer behind an APB-style port.
// Depends on clr_pkg.
module clr_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [clr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [clr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output clr_pkg::t_clip_cfg              o_cfg
);
    import clr_pkg::*;

    t_clip_cfg r_cfg;
    t_reg_idx  reg_idx;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CLIP_LEFT:   r_cfg.clip_left   <= pwdata[CLIP_POS_W-1:0];
                REG_CLIP_TOP:    r_cfg.clip_top    <= pwdata[CLIP_POS_W-1:0];
                REG_CLIP_WIDTH:  r_cfg.clip_width  <= pwdata[CLIP_SIZE_W-1:0];
                REG_CLIP_HEIGHT: r_cfg.clip_height <= pwdata[CLIP_SIZE_W-1:0];
                REG_ROW_STRIDE:  r_cfg.row_stride  <= pwdata[CLIP_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CLIP_LEFT:   prdata = CFG_DATA_W'(r_cfg.clip_left);
            REG_CLIP_TOP:    prdata = CFG_DATA_W'(r_cfg.clip_top);
            REG_CLIP_WIDTH:  prdata = CFG_DATA_W'(r_cfg.clip_width);
            REG_CLIP_HEIGHT: prdata = CFG_DATA_W'(r_cfg.clip_height);
            REG_ROW_STRIDE:  prdata = CFG_DATA_W'(r_cfg.row_stride);
            default:         prdata = '0;
        endcase
    end

endmodule

/* sv/clr_walk.sv */
// Bresenham walker: line state and one error-term step per accepted active-line step.
// Its state registers double as the pixel stage feeding clr_emit. Depends on clr_pkg.
module clr_walk #(
    parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_command,
    input  logic [COORD_BITS-1:0]        i_start_x,
    input  logic [COORD_BITS-1:0]        i_start_y,
    input  logic [COORD_BITS-1:0]        i_end_x,
    input  logic [COORD_BITS-1:0]        i_end_y,
    input  logic [clr_pkg::COLOR_W-1:0]  i_color_word,
    output logic                         o_pix_valid,
    input  logic                         i_pix_stall,
    output clr_pkg::t_pix_ctl            o_ctl,
    output logic [COORD_BITS-1:0]        o_col,
    output logic [COORD_BITS-1:0]        o_row,
    output logic [clr_pkg::COLOR_W-1:0]  o_color
);
    import clr_pkg::*;

    localparam int DW  = COORD_BITS + 1;  // |dx|, -|dy|
    localparam int EW  = COORD_BITS + 2;  // error term
    localparam int E2W = COORD_BITS + 3;  // doubled error and sums

    logic [COORD_BITS-1:0] r_cur_col, r_cur_row, r_target_col, r_target_row;
    logic [DW-1:0]         r_delta_col, r_neg_delta_row;
    logic                  r_step_col_neg, r_step_row_neg;
    logic [EW-1:0]         r_error_term;
    logic [COLOR_W-1:0]    r_line_color;
    logic                  r_line_active;
    logic                  r_valid, r_live;

    logic [COORD_BITS-1:0] n_cur_col, n_cur_row, n_target_col, n_target_row;
    logic [DW-1:0]         n_delta_col, n_neg_delta_row;
    logic                  n_step_col_neg, n_step_row_neg;
    logic [EW-1:0]         n_error_term;
    logic [COLOR_W-1:0]    n_line_color;
    logic                  n_line_active, n_live;

    logic          advance, accept, is_start;
    logic [DW-1:0] dx, dy;
    logic [E2W-1:0] e2, ndr_x, dc_x, err_x, err_sum;
    logic          col_go, row_go;

    assign advance    = !r_valid || !i_pix_stall;
    assign accept     = i_in_valid && advance;
    assign o_in_stall = !advance;
    assign is_start   = (t_cmd'(i_command) == CMD_START);

    assign dx = {i_end_x[COORD_BITS-1], i_end_x} - {i_start_x[COORD_BITS-1], i_start_x};
    assign dy = {i_end_y[COORD_BITS-1], i_end_y} - {i_start_y[COORD_BITS-1], i_start_y};

    // One Bresenham step; both tests use the error term from before the step.
    assign e2     = {r_error_term, 1'b0};
    assign ndr_x  = {{2{r_neg_delta_row[DW-1]}}, r_neg_delta_row};
    assign dc_x   = {{2{r_delta_col[DW-1]}}, r_delta_col};
    assign err_x  = {r_error_term[EW-1], r_error_term};
    assign col_go = $signed(e2) >= $signed(ndr_x);
    assign row_go = $signed(e2) <= $signed(dc_x);
    assign err_sum = err_x + (col_go ? ndr_x : '0) + (row_go ? dc_x : '0);

    always_comb begin
        n_cur_col       = r_cur_col;
        n_cur_row       = r_cur_row;
        n_target_col    = r_target_col;
        n_target_row    = r_target_row;
        n_delta_col     = r_delta_col;
        n_neg_delta_row = r_neg_delta_row;
        n_step_col_neg  = r_step_col_neg;
        n_step_row_neg  = r_step_row_neg;
        n_error_term    = r_error_term;
        n_line_color    = r_line_color;
        n_live          = 1'b1;
        if (is_start) begin
            n_cur_col       = i_start_x;
            n_cur_row       = i_start_y;
            n_target_col    = i_end_x;
            n_target_row    = i_end_y;
            n_line_color    = i_color_word;
            n_delta_col     = dx[DW-1] ? -dx : dx;
            n_neg_delta_row = dy[DW-1] ? dy : -dy;
            n_step_col_neg  = !($signed(i_start_x) < $signed(i_end_x));
            n_step_row_neg  = !($signed(i_start_y) < $signed(i_end_y));
            n_error_term    = {n_delta_col[DW-1], n_delta_col}
                            + {n_neg_delta_row[DW-1], n_neg_delta_row};
        end else if (r_line_active) begin
            n_error_term = err_sum[EW-1:0];
            if (col_go) begin
                n_cur_col = r_cur_col + (r_step_col_neg ? {COORD_BITS{1'b1}}
                                                        : COORD_BITS'(1));
            end
            if (row_go) begin
                n_cur_row = r_cur_row + (r_step_row_neg ? {COORD_BITS{1'b1}}
                                                        : COORD_BITS'(1));
            end
        end else begin
            // A step with no line drawn leaves the state alone.
            n_live = 1'b0;
        end
        n_line_active = !((n_cur_col == n_target_col) && (n_cur_row == n_target_row));
        if (!is_start && !r_line_active) begin
            n_line_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col       <= '0;
            r_cur_row       <= '0;
            r_target_col    <= '0;
            r_target_row    <= '0;
            r_delta_col     <= '0;
            r_neg_delta_row <= '0;
            r_step_col_neg  <= 1'b0;
            r_step_row_neg  <= 1'b0;
            r_error_term    <= '0;
            r_line_color    <= '0;
            r_line_active   <= 1'b0;
            r_live          <= 1'b0;
            r_valid         <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= i_in_valid;
            end
            if (accept) begin
                r_cur_col       <= n_cur_col;
                r_cur_row       <= n_cur_row;
                r_target_col    <= n_target_col;
                r_target_row    <= n_target_row;
                r_delta_col     <= n_delta_col;
                r_neg_delta_row <= n_neg_delta_row;
                r_step_col_neg  <= n_step_col_neg;
                r_step_row_neg  <= n_step_row_neg;
                r_error_term    <= n_error_term;
                r_line_color    <= n_line_color;
                r_line_active   <= n_line_active;
                r_live          <= n_live;
            end
        end
    end

    assign o_pix_valid = r_valid;
    assign o_ctl.live  = r_live;
    assign o_ctl.last  = !r_line_active;
    assign o_col       = r_cur_col;
    assign o_row       = r_cur_row;
    assign o_color     = r_line_color;

    // An active line has not yet reached its endpoint.
    a_active_not_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> !((r_cur_col == r_target_col) && (r_cur_row == r_target_row)))
        else $error("active line sits on its endpoint");

    // A step of an active line moves the column by at most one pixel.
    a_col_unit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_start && r_line_active) |=>
            ((r_cur_col == $past(r_cur_col))
             || (r_cur_col == $past(r_cur_col) + COORD_BITS'(1))
             || (r_cur_col == $past(r_cur_col) - COORD_BITS'(1))))
        else $error("column jumped by more than one pixel");

    // A step of an active line always moves the pixel somewhere.
    a_step_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_start && r_line_active) |=>
            ((r_cur_col != $past(r_cur_col)) || (r_cur_row != $past(r_cur_row))))
        else $error("step left the pixel in place");

endmodule

/* sv/clr_emit.sv */
// Output stage: clip test, framebuffer address and the result register.
// Depends on clr_pkg.
module clr_emit #(
    parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = clr_pkg::ADDR_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  clr_pkg::t_clip_cfg           i_cfg,
    input  logic                         i_pix_valid,
    output logic                         o_pix_stall,
    input  clr_pkg::t_pix_ctl            i_ctl,
    input  logic [COORD_BITS-1:0]        i_col,
    input  logic [COORD_BITS-1:0]        i_row,
    input  logic [clr_pkg::COLOR_W-1:0]  i_color,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_write_enable,
    output logic [ADDR_BITS-1:0]         o_pixel_address,
    output logic [clr_pkg::COLOR_W-1:0]  o_pixel_data,
    output logic                         o_last
);
    import clr_pkg::*;

    localparam int CMP_W = ((COORD_BITS > CLIP_SIZE_W + 1) ? COORD_BITS : CLIP_SIZE_W + 1) + 1;
    localparam int PROD_W = COORD_BITS + CLIP_SIZE_W + 1;
    localparam int SUM_W  = (PROD_W > ADDR_BITS) ? PROD_W : ADDR_BITS;

    logic                 r_out_valid, r_write_enable, r_last;
    logic [ADDR_BITS-1:0] r_pixel_address;
    logic [COLOR_W-1:0]   r_pixel_data;

    logic             advance, load, in_clip;
    logic [CMP_W-1:0] col_x, row_x, left_x, top_x, right_x, bottom_x;
    logic [SUM_W-1:0] addr_sum;

    assign advance     = !r_out_valid || !i_out_stall;
    assign load        = i_pix_valid && advance;
    assign o_pix_stall = !advance;

    assign col_x    = {{(CMP_W-COORD_BITS){i_col[COORD_BITS-1]}}, i_col};
    assign row_x    = {{(CMP_W-COORD_BITS){i_row[COORD_BITS-1]}}, i_row};
    assign left_x   = CMP_W'(i_cfg.clip_left);
    assign top_x    = CMP_W'(i_cfg.clip_top);
    assign right_x  = left_x + CMP_W'(i_cfg.clip_width);
    assign bottom_x = top_x + CMP_W'(i_cfg.clip_height);

    assign in_clip = i_ctl.live
                 && ($signed(col_x) >= $signed(left_x)) && ($signed(col_x) < $signed(right_x))
                 && ($signed(row_x) >= $signed(top_x)) && ($signed(row_x) < $signed(bottom_x));

    // Row and column are non-negative whenever the pixel is inside the clip.
    assign addr_sum = SUM_W'(i_row) * SUM_W'(i_cfg.row_stride) + SUM_W'(i_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_write_enable  <= in_clip;
            r_pixel_address <= in_clip ? addr_sum[ADDR_BITS-1:0] : '0;
            r_pixel_data    <= i_ctl.live ? i_color : '0;
            r_last          <= i_ctl.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_enable  = r_write_enable;
    assign o_pixel_address = r_pixel_address;
    assign o_pixel_data    = r_pixel_data;
    assign o_last          = r_last;

    // A word without a write always carries a zero address.
    a_no_write_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_write_enable) |-> (r_pixel_address == '0))
        else $error("address set on a word without a write");

    // A stalled result is not overwritten by the pixel stage.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_pixel_address)
                                          && $stable(r_last)))
        else $error("result changed while stalled");

endmodule

/* sv/clipped_line_rasterizer.sv */
// Bresenham line rasterizer with a clip rectangle. A start word loads both endpoints and the
// pixel value and yields the first pixel; each step word of an active line yields the next
// one. The block takes one word per clock while no stall holds it and returns one result per
// word: the walker register holds the line state and the new pixel, and the output register
// after it holds the clip flag, the address row*row_stride+col and the last flag. The rate is
// set by the error-term update in the walker, which feeds back on itself.
// Clip and stride registers should be written only while no word is in flight.
module clipped_line_rasterizer #(
    parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = clr_pkg::ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [clr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [clr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [COORD_BITS-1:0]           i_start_x,
    input  logic [COORD_BITS-1:0]           i_start_y,
    input  logic [COORD_BITS-1:0]           i_end_x,
    input  logic [COORD_BITS-1:0]           i_end_y,
    input  logic [clr_pkg::COLOR_W-1:0]     i_color_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_write_enable,
    output logic [ADDR_BITS-1:0]            o_pixel_address,
    output logic [clr_pkg::COLOR_W-1:0]     o_pixel_data,
    output logic                            o_last
);
    import clr_pkg::*;

    t_clip_cfg             cfg;
    t_pix_ctl              pix_ctl;
    logic                  pix_valid, pix_stall;
    logic [COORD_BITS-1:0] pix_col, pix_row;
    logic [COLOR_W-1:0]    pix_color;

    clr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    clr_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_color_word (i_color_word),
        .o_pix_valid  (pix_valid),
        .i_pix_stall  (pix_stall),
        .o_ctl        (pix_ctl),
        .o_col        (pix_col),
        .o_row        (pix_row),
        .o_color      (pix_color)
    );

    clr_emit #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_pix_valid     (pix_valid),
        .o_pix_stall     (pix_stall),
        .i_ctl           (pix_ctl),
        .i_col           (pix_col),
        .i_row           (pix_row),
        .i_color         (pix_color),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_enable  (o_write_enable),
        .o_pixel_address (o_pixel_address),
        .o_pixel_data    (o_pixel_data),
        .o_last          (o_last)
    );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for clipped_line_rasterizer: a short directed table, then random
// clip settings and line walks checked against a cycle-free Bresenham predictor.
// Depends on clr_pkg (sv/clr_pkg.sv) and the clipped_line_rasterizer RTL.
module testbench;
    import clr_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int AW = ADDR_BITS_DEF;
    localparam int HANG_LIMIT = 3000;
    localparam int RANDOM_PHASES = 10;
    localparam int WORDS_PER_PHASE = 145;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [31:0]   data;
        logic          last;
    } t_pixel_res;

    typedef struct {
        int            cfg;    // clip setting to load first, -1 keeps the current one
        t_cmd          cmd;
        logic [CW-1:0] sx, sy, ex, ey;
        logic [31:0]   color;
        bit            typed;  // res holds the known answer
        t_pixel_res    res;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_command = 1'b0;
    logic [CW-1:0]         i_start_x = '0;
    logic [CW-1:0]         i_start_y = '0;
    logic [CW-1:0]         i_end_x = '0;
    logic [CW-1:0]         i_end_y = '0;
    logic [COLOR_W-1:0]    i_color_word = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_write_enable;
    logic [AW-1:0]         o_pixel_address;
    logic [COLOR_W-1:0]    o_pixel_data;
    logic                  o_last;

    // Predictor copy of the walker state and the clip registers.
    logic signed [CW-1:0] pen_col = '0, pen_row = '0, goal_col = '0, goal_row = '0;
    int                   span_col = 0, neg_span_row = 0, bres_err = 0;
    bit                   col_back = 1'b0, row_back = 1'b0, drawing = 1'b0;
    logic [31:0]          ink = '0;
    t_clip_cfg            clip_now = '0;

    t_pixel_res pending_pixels[$];
    t_pixel_res seen_pix, want_pix;

    int err_cnt = 0, n_words = 0, n_pixels = 0, n_written = 0, n_settings = 0;
    int burst_left = 0, hang_cnt = 0;
    int stall_mode = 0, stall_hold = 0, stall_tick = 0;

    t_clip_cfg cfg_tab[3] = '{
        '{12'd0,    12'd0,    13'd4096, 13'd4096, 13'd4096},
        '{12'd10,   12'd20,   13'd4,    13'd3,    13'd100},
        '{12'd4095, 12'd4095, 13'd4096, 13'd4096, 13'd0}
    };

    // cfg, command, start x/y, end x/y, color, typed, known result
    t_dir_row dir_tab[26] = '{
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b1,
          '{1'b0, 24'h0, 32'h0, 1'b1}},
        '{-1, CMD_START, 12'h800, 12'h800, 12'h800, 12'h800, 32'hFFFFFFFF, 1'b1,
          '{1'b0, 24'h0, 32'hFFFFFFFF, 1'b1}},
        '{-1, CMD_STEP,  12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFFFFFF, 1'b1,
          '{1'b0, 24'h0, 32'h0, 1'b1}},
        '{-1, CMD_START, 12'h000, 12'h000, 12'h003, 12'h001, 32'h0, 1'b1,
          '{1'b0, 24'h0, 32'h0, 1'b0}},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{0,  CMD_START, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 32'hA5A5A5A5, 1'b1,
          '{1'b1, 24'h7FF7FF, 32'hA5A5A5A5, 1'b1}},
        '{-1, CMD_START, 12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b1,
          '{1'b1, 24'h0, 32'h0, 1'b1}},
        '{-1, CMD_START, 12'hFFF, 12'h000, 12'h002, 12'h000, 32'h12345678, 1'b1,
          '{1'b0, 24'h0, 32'h12345678, 1'b0}},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_START, 12'h7FF, 12'h800, 12'h800, 12'h7FF, 32'h5A5A5A5A, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_START, 12'h005, 12'h005, 12'h005, 12'h000, 32'h0F0F0F0F, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{1,  CMD_START, 12'h009, 12'h014, 12'h00E, 12'h016, 32'hC3C3C3C3, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b0, '0},
        '{-1, CMD_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 32'h0, 1'b1,
          '{1'b0, 24'h0, 32'h0, 1'b1}},
        '{2,  CMD_START, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 32'h3C3C3C3C, 1'b1,
          '{1'b0, 24'h0, 32'h3C3C3C3C, 1'b1}}
    };

    clipped_line_rasterizer DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A start load or one Bresenham step of the line walk, plus the clip test and address.
    function automatic t_pixel_res trace_pixel(t_cmd cmd, logic [CW-1:0] sx,
            logic [CW-1:0] sy, logic [CW-1:0] ex, logic [CW-1:0] ey, logic [31:0] color);
        t_pixel_res res;
        int         dx, dy, e2, col, row, lft, top, wid, hgt;
        longint     lin;
        bit         at_end;
        res = '0;
        if (cmd == CMD_START) begin
            pen_col = sx;
            pen_row = sy;
            goal_col = ex;
            goal_row = ey;
            ink = color;
            dx = int'(goal_col) - int'(pen_col);
            dy = int'(goal_row) - int'(pen_row);
            span_col = (dx < 0) ? -dx : dx;
            neg_span_row = (dy < 0) ? dy : -dy;
            col_back = !(pen_col < goal_col);
            row_back = !(pen_row < goal_row);
            bres_err = span_col + neg_span_row;
        end else begin
            if (!drawing) begin
                // Nothing to walk: an empty word that only flags last.
                res.last = 1'b1;
                return res;
            end
            e2 = 2 * bres_err;
            if (e2 >= neg_span_row) begin
                bres_err += neg_span_row;
                pen_col = col_back ? pen_col - 12'sd1 : pen_col + 12'sd1;
            end
            if (e2 <= span_col) begin
                bres_err += span_col;
                pen_row = row_back ? pen_row - 12'sd1 : pen_row + 12'sd1;
            end
        end
        at_end = (pen_col == goal_col) && (pen_row == goal_row);
        drawing = !at_end;
        col = int'(pen_col);
        row = int'(pen_row);
        lft = int'(clip_now.clip_left);
        top = int'(clip_now.clip_top);
        wid = int'(clip_now.clip_width);
        hgt = int'(clip_now.clip_height);
        if (col >= lft && col < lft + wid && row >= top && row < top + hgt) begin
            res.we = 1'b1;
            lin = longint'(row) * longint'(clip_now.row_stride) + longint'(col);
            res.addr = lin[AW-1:0];
        end
        res.data = ink;
        res.last = at_end;
        return res;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    // Coordinates around the clip rectangle so that lines cross its edges.
    function automatic int near_coord(int base, int span);
        int s;
        s = (span > 400) ? 400 : span;
        return clamp_coord(base - 6 + int'($urandom_range(0, s + 12)));
    endfunction

    function automatic logic [31:0] with_junk(logic [12:0] v, int bits);
        logic [31:0] w;
        int          b;
        w = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
        for (b = 0; b < bits; b++) w[b] = v[b];
        return w;
    endfunction

    function automatic t_clip_cfg pick_clip(int p);
        t_clip_cfg c;
        c.clip_left = 12'($urandom_range(0, 60));
        c.clip_top = 12'($urandom_range(0, 60));
        c.clip_width = 13'($urandom_range(0, 64));
        c.clip_height = 13'($urandom_range(0, 64));
        c.row_stride = 13'($urandom_range(0, 4096));
        if ($urandom_range(0, 4) == 0) begin
            c.clip_left = 12'($urandom_range(1990, 2047));
            c.clip_top = 12'($urandom_range(1990, 2047));
        end
        case (p)
            0: c = '{12'd0, 12'd0, 13'd4096, 13'd4096, 13'd4096};
            1: c.clip_width = '0;
            2: c.clip_height = '0;
            3: c = '{12'd2040, 12'd2040, 13'd4096, 13'd4096, 13'd4096};
            4: c.row_stride = '0;
            default: ;
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("mismatch at pixel %0d: %s got 0x%0h, want 0x%0h",
                     n_pixels, what, got, want);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_clip(t_clip_cfg c);
        write_reg(REG_CLIP_LEFT, with_junk(13'(c.clip_left), CLIP_POS_W));
        write_reg(REG_CLIP_TOP, with_junk(13'(c.clip_top), CLIP_POS_W));
        write_reg(REG_CLIP_WIDTH, with_junk(c.clip_width, CLIP_SIZE_W));
        write_reg(REG_CLIP_HEIGHT, with_junk(c.clip_height, CLIP_SIZE_W));
        write_reg(REG_ROW_STRIDE, with_junk(c.row_stride, CLIP_SIZE_W));
        // An address past the last register must leave the setting alone.
        write_reg(3'(int'(REG_ROW_STRIDE) + 1 + int'($urandom_range(0, 2))), $urandom);
        clip_now = c;
        n_settings++;
    endtask

    // Stop feeding, let every pending pixel come back, then allow for the pipeline.
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_word(t_cmd cmd, logic [CW-1:0] sx, logic [CW-1:0] sy,
            logic [CW-1:0] ex, logic [CW-1:0] ey, logic [31:0] color,
            bit typed, t_pixel_res typed_res);
        t_pixel_res predicted;
        int         gap;
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x <= ex;
        i_end_y <= ey;
        i_color_word <= color;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = trace_pixel(cmd, sx, sy, ex, ey, color);
        if (typed) predicted = typed_res;
        pending_pixels = {pending_pixels, predicted};
        n_words++;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Mostly complete lines near the clip window, some cut short, some stray steps.
    task automatic random_phase(int n_items);
        int sent, cap, walked, spread, c0, r0, c1, r1;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 8) begin
                send_word(CMD_STEP, CW'($urandom), CW'($urandom), CW'($urandom),
                          CW'($urandom), $urandom, 1'b0, '0);
                sent++;
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    c0 = int'($urandom_range(0, 4095)) - 2048;
                    r0 = int'($urandom_range(0, 4095)) - 2048;
                    c1 = int'($urandom_range(0, 4095)) - 2048;
                    r1 = int'($urandom_range(0, 4095)) - 2048;
                end else begin
                    c0 = near_coord(int'(clip_now.clip_left), int'(clip_now.clip_width));
                    r0 = near_coord(int'(clip_now.clip_top), int'(clip_now.clip_height));
                    spread = ($urandom_range(0, 4) == 0) ? 200 : 12;
                    c1 = clamp_coord(c0 + int'($urandom_range(0, 2 * spread)) - spread);
                    r1 = clamp_coord(r0 + int'($urandom_range(0, 2 * spread)) - spread);
                end
                send_word(CMD_START, c0[CW-1:0], r0[CW-1:0], c1[CW-1:0], r1[CW-1:0],
                          $urandom, 1'b0, '0);
                sent++;
                cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 300;
                walked = 0;
                while (drawing && walked < cap && sent < n_items) begin
                    send_word(CMD_STEP, CW'($urandom), CW'($urandom), CW'($urandom),
                              CW'($urandom), $urandom, 1'b0, '0);
                    sent++;
                    walked++;
                end
            end
        end
    endtask

    // Receiver back-pressure: free running, light, heavy and periodic stretches.
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_hold = $urandom_range(20, 200);
        end else begin
            stall_hold--;
        end
        stall_tick++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 30);
            2: i_out_stall <= ($urandom_range(0, 99) < 75);
            default: i_out_stall <= (stall_tick % 5 >= 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            seen_pix = {o_write_enable, o_pixel_address, o_pixel_data, o_last};
            if (pending_pixels.size() == 0) begin
                report_mismatch("word with nothing pending", seen_pix, 0);
            end else begin
                want_pix = pending_pixels.pop_front();
                if (seen_pix.we !== want_pix.we)
                    report_mismatch("write_enable", seen_pix.we, want_pix.we);
                if (seen_pix.addr !== want_pix.addr)
                    report_mismatch("pixel_address", seen_pix.addr, want_pix.addr);
                if (seen_pix.data !== want_pix.data)
                    report_mismatch("pixel_data", seen_pix.data, want_pix.data);
                if (seen_pix.last !== want_pix.last)
                    report_mismatch("last", seen_pix.last, want_pix.last);
                if (want_pix.we) n_written++;
                n_pixels++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall) ||
            (psel && penable && pready === 1'b1))
            hang_cnt = 0;
        else
            hang_cnt++;
        if (hang_cnt >= HANG_LIMIT) begin
            $display("no progress for %0d cycles", HANG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int k, p;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (k = 0; k < 26; k++) begin
            if (dir_tab[k].cfg >= 0) begin
                drain_pipe();
                set_clip(cfg_tab[dir_tab[k].cfg]);
            end
            send_word(dir_tab[k].cmd, dir_tab[k].sx, dir_tab[k].sy, dir_tab[k].ex,
                      dir_tab[k].ey, dir_tab[k].color, dir_tab[k].typed, dir_tab[k].res);
        end
        for (p = 0; p < RANDOM_PHASES; p++) begin
            drain_pipe();
            set_clip(pick_clip(p));
            random_phase(WORDS_PER_PHASE);
        end
        drain_pipe();
        repeat (4) @(posedge i_clk);
        $display("covered %0d input words under %0d clip settings", n_words, n_settings);
        $display("%0d pixels compared, %0d inside the clip, %0d mismatches",
                 n_pixels, n_written, err_cnt);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
